>>> hdl/q2e_pkg.sv
`timescale 1ns / 1ps

package q2e_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;
    localparam int SQRT_CELLS       = 32;
    localparam int WW               = 36;

    typedef logic signed [WW-1:0] wide_t;

    localparam wide_t ONE_Q30 = 36'sd1073741824;
    localparam wide_t PI_Q30  = 36'sd3373259426;

    typedef struct packed {
        wide_t sr;
        wide_t cr;
        wide_t sy;
        wide_t cy;
        wide_t sp;
        logic  clamp;
    } terms_t;

    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] root;
        terms_t      t;
    } sqrt_t;

    typedef struct packed {
        wide_t x;
        wide_t y;
        wide_t z;
        logic  zero;
    } lane_t;

    typedef struct packed {
        lane_t [2:0] lane;
        logic        clamp;
    } rot_t;

    function automatic logic [29:0] atan_step(input int i);
        logic [29:0] a;
        unique case (i)
            0:       a = 30'd843314856;
            1:       a = 30'd497837829;
            2:       a = 30'd263043836;
            3:       a = 30'd133525158;
            4:       a = 30'd67021686;
            5:       a = 30'd33543515;
            6:       a = 30'd16775850;
            7:       a = 30'd8388437;
            8:       a = 30'd4194282;
            9:       a = 30'd2097149;
            10:      a = 30'd1048575;
            11:      a = 30'd524287;
            12:      a = 30'd262143;
            13:      a = 30'd131071;
            14:      a = 30'd65535;
            15:      a = 30'd32767;
            16:      a = 30'd16383;
            17:      a = 30'd8191;
            18:      a = 30'd4095;
            19:      a = 30'd2047;
            20:      a = 30'd1023;
            21:      a = 30'd511;
            22:      a = 30'd255;
            23:      a = 30'd127;
            default: a = 30'd0;
        endcase
        return a;
    endfunction

endpackage

>>> hdl/quaternion_to_roll_pitch_yaw_core.sv
`timescale 1ns / 1ps

// Channel  Handshake             Payload
// input    in_valid / in_ready   quat_w, quat_x, quat_y, quat_z
// output   out_valid / out_ready roll_angle, pitch_angle, yaw_angle, pitch_clamped
//
// One request is accepted per cycle while the pipeline has room; it passes through
// three product stages, 32 square root cells, one pre-rotation stage, one CORDIC
// cell per step for all three angles (at most ATAN_LEN steps), one output stage.
// Reset empties every stage. A stall at the output backs up stage by stage, so
// bubbles are squeezed out and input is taken while any stage has room.

module quaternion_to_roll_pitch_yaw_core
    import q2e_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] quat_w,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] roll_angle,
    output logic signed [15:0] pitch_angle,
    output logic signed [15:0] yaw_angle,
    output logic               pitch_clamped
);

    localparam int RUN = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

    sqrt_t sq_d [SQRT_CELLS+1];
    logic  sq_v [SQRT_CELLS+1];
    logic  sq_r [SQRT_CELLS+1];
    rot_t  ro_d [RUN+1];
    logic  ro_v [RUN+1];
    logic  ro_r [RUN+1];

    logic                valid_reg;
    logic                fin_ready;
    logic signed [15:0]  ang_reg [3];
    logic signed [15:0]  ang_next [3];
    logic                clamp_reg;
    logic signed [WW-1:0] rnd [3];
    logic signed [WW-18:0] shf [3];

    q2e_terms u_terms (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .w         (quat_w),
        .x         (quat_x),
        .y         (quat_y),
        .z         (quat_z),
        .out_valid (sq_v[0]),
        .out_ready (sq_r[0]),
        .out_data  (sq_d[0])
    );

    for (genvar k = 0; k < SQRT_CELLS; k++)
    begin : g_sqrt
        q2e_sqrt_cell #(.STEP(k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_v[k]),
            .in_ready  (sq_r[k]),
            .in_data   (sq_d[k]),
            .out_valid (sq_v[k+1]),
            .out_ready (sq_r[k+1]),
            .out_data  (sq_d[k+1])
        );
    end

    q2e_prerot u_prerot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_v[SQRT_CELLS]),
        .in_ready  (sq_r[SQRT_CELLS]),
        .in_data   (sq_d[SQRT_CELLS]),
        .out_valid (ro_v[0]),
        .out_ready (ro_r[0]),
        .out_data  (ro_d[0])
    );

    for (genvar k = 0; k < RUN; k++)
    begin : g_cordic
        q2e_cordic_cell #(.STEP(k)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (ro_v[k]),
            .in_ready  (ro_r[k]),
            .in_data   (ro_d[k]),
            .out_valid (ro_v[k+1]),
            .out_ready (ro_r[k+1]),
            .out_data  (ro_d[k+1])
        );
    end

    assign fin_ready   = !valid_reg || out_ready;
    assign ro_r[RUN]   = fin_ready;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd[i] = ro_d[RUN].lane[i].z + wide_t'(36'sd65536);
            shf[i] = rnd[i][WW-1:17];
            if (ro_d[RUN].lane[i].zero)
            begin
                ang_next[i] = '0;
            end
            else if (shf[i] > 19'sd32767)
            begin
                ang_next[i] = 16'sh7fff;
            end
            else if (shf[i] < -19'sd32768)
            begin
                ang_next[i] = 16'sh8000;
            end
            else
            begin
                ang_next[i] = shf[i][15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (fin_ready)
        begin
            valid_reg <= ro_v[RUN];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_ready && ro_v[RUN])
        begin
            ang_reg   <= ang_next;
            clamp_reg <= ro_d[RUN].clamp;
        end
    end

    assign out_valid     = valid_reg;
    assign roll_angle    = ang_reg[0];
    assign pitch_angle   = ang_reg[1];
    assign yaw_angle     = ang_reg[2];
    assign pitch_clamped = clamp_reg;

endmodule

>>> hdl/q2e_terms.sv
`timescale 1ns / 1ps

module q2e_terms
    import q2e_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] w,
    input  logic signed [15:0] x,
    input  logic signed [15:0] y,
    input  logic signed [15:0] z,
    output logic               out_valid,
    input  logic               out_ready,
    output sqrt_t              out_data
);

    logic v1_reg, v2_reg, v3_reg;
    logic r1, r2, r3;
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, wz_reg, xy_reg, zz_reg, wy_reg, zx_reg;
    terms_t t2_reg, t2_next;
    sqrt_t  s3_reg, s3_next;
    wide_t  sp_raw, sp_mag;
    logic [61:0] sq;

    assign r3       = !v3_reg || out_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    always_comb
    begin
        sp_raw        = (wide_t'(wy_reg) - wide_t'(zx_reg)) <<< 1;
        t2_next.sr    = (wide_t'(wx_reg) + wide_t'(yz_reg)) <<< 1;
        t2_next.cr    = ONE_Q30 - ((wide_t'(xx_reg) + wide_t'(yy_reg)) <<< 1);
        t2_next.sy    = (wide_t'(wz_reg) + wide_t'(xy_reg)) <<< 1;
        t2_next.cy    = ONE_Q30 - ((wide_t'(yy_reg) + wide_t'(zz_reg)) <<< 1);
        t2_next.sp    = sp_raw;
        t2_next.clamp = 1'b0;
        if (sp_raw > ONE_Q30)
        begin
            t2_next.sp    = ONE_Q30;
            t2_next.clamp = 1'b1;
        end
        else if (sp_raw < -ONE_Q30)
        begin
            t2_next.sp    = -ONE_Q30;
            t2_next.clamp = 1'b1;
        end
    end

    always_comb
    begin
        sp_mag        = t2_reg.sp[WW-1] ? -t2_reg.sp : t2_reg.sp;
        sq            = sp_mag[30:0] * sp_mag[30:0];
        s3_next.rem   = (64'd1 << 60) - {2'b00, sq};
        s3_next.root  = 64'd0;
        s3_next.t     = t2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= in_valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r1 && in_valid)
        begin
            wx_reg <= w * x;
            yz_reg <= y * z;
            xx_reg <= x * x;
            yy_reg <= y * y;
            wz_reg <= w * z;
            xy_reg <= x * y;
            zz_reg <= z * z;
            wy_reg <= w * y;
            zx_reg <= z * x;
        end
        if (r2 && v1_reg)
        begin
            t2_reg <= t2_next;
        end
        if (r3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = s3_reg;

endmodule

>>> hdl/q2e_sqrt_cell.sv
`timescale 1ns / 1ps

module q2e_sqrt_cell
    import q2e_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  sqrt_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output sqrt_t out_data
);

    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

    logic        valid_reg;
    sqrt_t       data_reg, data_next;
    logic [63:0] trial;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        trial     = in_data.root + BIT;
        data_next = in_data;
        if (in_data.rem >= trial)
        begin
            data_next.rem  = in_data.rem - trial;
            data_next.root = (in_data.root >> 1) + BIT;
        end
        else
        begin
            data_next.root = in_data.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hdl/q2e_prerot.sv
`timescale 1ns / 1ps

module q2e_prerot
    import q2e_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  sqrt_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output rot_t  out_data
);

    logic  valid_reg;
    rot_t  data_reg, data_next;
    wide_t ys [3];
    wide_t xs [3];

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        ys[0] = in_data.t.sr;
        xs[0] = in_data.t.cr;
        ys[1] = in_data.t.sp;
        xs[1] = wide_t'({1'b0, in_data.root[30:0]});
        ys[2] = in_data.t.sy;
        xs[2] = in_data.t.cy;
        data_next.clamp = in_data.t.clamp;
        for (int i = 0; i < 3; i++)
        begin
            data_next.lane[i].zero = (xs[i] == '0) && (ys[i] == '0);
            data_next.lane[i].x    = xs[i];
            data_next.lane[i].y    = ys[i];
            data_next.lane[i].z    = '0;
            if (xs[i][WW-1])
            begin
                data_next.lane[i].x = -xs[i];
                data_next.lane[i].y = -ys[i];
                data_next.lane[i].z = ys[i][WW-1] ? -PI_Q30 : PI_Q30;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> hdl/q2e_cordic_cell.sv
`timescale 1ns / 1ps

module q2e_cordic_cell
    import q2e_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  rot_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output rot_t out_data
);

    localparam wide_t ANG = wide_t'({6'b000000, atan_step(STEP)});

    logic  valid_reg;
    rot_t  data_reg, data_next;
    wide_t xs [3];
    wide_t ys [3];

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next = in_data;
        for (int i = 0; i < 3; i++)
        begin
            xs[i] = in_data.lane[i].x >>> STEP;
            ys[i] = in_data.lane[i].y >>> STEP;
            if (!in_data.lane[i].y[WW-1])
            begin
                data_next.lane[i].x = in_data.lane[i].x + ys[i];
                data_next.lane[i].y = in_data.lane[i].y - xs[i];
                data_next.lane[i].z = in_data.lane[i].z + ANG;
            end
            else
            begin
                data_next.lane[i].x = in_data.lane[i].x - ys[i];
                data_next.lane[i].y = in_data.lane[i].y + xs[i];
                data_next.lane[i].z = in_data.lane[i].z - ANG;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
